// ----- rtl/ipv4_header_generator_top_assert.svh -----
// assertion macros used by the port-level checker
`ifndef IPV4_HEADER_GENERATOR_TOP_ASSERT_SVH
`define IPV4_HEADER_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IPV4HG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IPV4HG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ipv4hg_pkg.sv -----
// types and constants of the ipv4 header generator
package ipv4hg_pkg;

    localparam int HDR_WORDS   = 10;
    localparam int HDR_BYTES   = 20;
    localparam int WORD_W      = 16;
    localparam int IDX_W       = 4;
    localparam int PADDR_W     = 3;

    localparam logic [3:0]        IP_VERSION  = 4'h4;
    localparam logic [3:0]        IP_IHL      = 4'h5;
    localparam logic [7:0]        IP_FLAGS_DF = 8'h40;
    localparam logic [7:0]        IP_TTL      = 8'd64;
    localparam logic [WORD_W-1:0] WORD_ONES   = 16'hFFFF;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HDR_WORDS - 1);

    // register index of the source address
    localparam logic REG_SOURCE_ADDRESS = 1'b0;

    typedef struct packed {
        logic [15:0] payload_length;
        logic [15:0] ident;
        logic [31:0] dest_address;
        logic [7:0]  protocol;
    } t_req;

    typedef struct packed {
        logic [15:0]      header_word;
        logic [IDX_W-1:0] word_index;
        logic             last;
    } t_word;

    typedef logic [HDR_WORDS-1:0][WORD_W-1:0] t_hdr_words;

endpackage

// ----- rtl/ipv4_header_generator_top.sv -----
// ipv4 header generator top level: request register, header buffer, apb register
//
// usage:
//   requests enter on i_in_valid / o_in_ready carrying payload length, ident,
//   destination address and protocol. each request yields ten 16-bit header
//   words on o_out_valid / i_out_ready, word_index 0..9, last on word 9.
//   the source address is written over the apb port (byte address 0); the user
//   must write it only while idle, and the block itself does not enforce this.
// path: a request accepted into an empty block passes the request register,
//   then the header buffer, before its first word is on the output; the header
//   and its checksum are built in one pass between the two registers.
// throughput: one output word per cycle while i_out_ready is high; the
//   request register takes the next request while the current header drains,
//   so words of consecutive headers follow without a gap.
// stall: when i_out_ready is low the current word holds; once the request
//   register is also full, o_in_ready drops.
// reset: i_rst_n low synchronously empties both stages and clears the source
//   address to 0.
module ipv4_header_generator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ipv4hg_pkg::t_req                    i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ipv4hg_pkg::t_word                   o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ipv4hg_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic                   r_in_valid;
    ipv4hg_pkg::t_req       r_in;
    logic                   r_busy;
    logic [ipv4hg_pkg::IDX_W-1:0] r_idx;
    logic [ipv4hg_pkg::IDX_W-1:0] n_idx;
    ipv4hg_pkg::t_hdr_words r_words;
    ipv4hg_pkg::t_hdr_words built;
    logic [31:0]            r_source;

    logic in_fire;
    logic out_fire;
    logic out_done;
    logic load;
    logic cfg_wr;

    assign out_fire   = r_busy && i_out_ready;
    assign out_done   = out_fire && (r_idx == ipv4hg_pkg::LAST_IDX);
    assign load       = r_in_valid && (!r_busy || out_done);
    assign o_in_ready = !r_in_valid || load;
    assign in_fire    = i_in_valid && o_in_ready;

    ipv4hg_hdr_build u_build (
        .i_req            (r_in),
        .i_source_address (r_source),
        .o_words          (built)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in;
        end
    end

    always_comb begin
        n_idx = r_idx + ipv4hg_pkg::IDX_W'(1);
    end

    // header buffer shifts down one word per accepted output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (out_done) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (out_fire) begin
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_words <= built;
        end else if (out_fire) begin
            r_words <= {ipv4hg_pkg::WORD_W'(0),
                        r_words[ipv4hg_pkg::HDR_WORDS-1:1]};
        end
    end

    assign o_out_valid       = r_busy;
    assign o_out.header_word = r_words[0];
    assign o_out.word_index  = r_idx;
    assign o_out.last        = (r_idx == ipv4hg_pkg::LAST_IDX);

    // apb register
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source <= '0;
        end else if (cfg_wr && (paddr[2] == ipv4hg_pkg::REG_SOURCE_ADDRESS)) begin
            r_source <= pwdata;
        end
    end

    always_comb begin
        case (paddr[2])
            ipv4hg_pkg::REG_SOURCE_ADDRESS: prdata = r_source;
            default:                        prdata = 32'h0000_0000;
        endcase
    end

endmodule

// ----- rtl/ipv4hg_hdr_build.sv -----
// builds the ten header words of one request, checksum included
module ipv4hg_hdr_build (
    input  ipv4hg_pkg::t_req       i_req,
    input  logic [31:0]            i_source_address,
    output ipv4hg_pkg::t_hdr_words o_words
);

    ipv4hg_pkg::t_hdr_words w;
    logic [19:0] sum_wide;
    logic [16:0] fold1;
    logic [16:0] fold2;
    logic [15:0] sum16;
    logic [15:0] chk;

    always_comb begin
        w[0] = {ipv4hg_pkg::IP_VERSION, ipv4hg_pkg::IP_IHL, 8'h00};
        w[1] = i_req.payload_length + 16'(ipv4hg_pkg::HDR_BYTES);
        w[2] = i_req.ident;
        w[3] = {ipv4hg_pkg::IP_FLAGS_DF, 8'h00};
        w[4] = {ipv4hg_pkg::IP_TTL, i_req.protocol};
        w[5] = 16'h0000;
        w[6] = i_source_address[31:16];
        w[7] = i_source_address[15:0];
        w[8] = i_req.dest_address[31:16];
        w[9] = i_req.dest_address[15:0];

        // plain sum then two end-around folds give the one's-complement sum
        sum_wide = 20'(w[0]) + 20'(w[1]) + 20'(w[2]) + 20'(w[3]) + 20'(w[4])
                 + 20'(w[6]) + 20'(w[7]) + 20'(w[8]) + 20'(w[9]);
        fold1 = 17'(sum_wide[15:0]) + 17'(sum_wide[19:16]);
        fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
        sum16 = fold2[15:0];
        chk   = ~sum16;
        if (chk == 16'h0000) begin
            chk = ipv4hg_pkg::WORD_ONES;
        end

        o_words    = w;
        o_words[5] = chk;
    end

endmodule

// ----- rtl/ipv4hg_checker.sv -----
// port-level checks of the ipv4 header generator, bound to the top level
`include "ipv4_header_generator_top_assert.svh"

module ipv4hg_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input ipv4hg_pkg::t_word              o_out
);

    logic out_fire;
    logic in_fire;

    assign out_fire = o_out_valid && i_out_ready;
    assign in_fire  = i_in_valid && o_in_ready;

    // a stalled word holds
    `IPV4HG_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out), "output word changed while stalled")

    // words of one header follow without a gap
    `IPV4HG_ASSERT_NEXT(a_hdr_cont, out_fire && !o_out.last,
        o_out_valid, "header interrupted before its last word")

    // word index steps by one within a header
    `IPV4HG_ASSERT_NEXT(a_idx_step, out_fire && !o_out.last,
        o_out.word_index == ($past(o_out.word_index) + ipv4hg_pkg::IDX_W'(1)),
        "word index did not advance by one")

    // an accepted request is followed by a valid word on the output
    `IPV4HG_ASSERT_NOW(a_req_out, in_fire, ##2 o_out_valid,
        "accepted request produced no header")

endmodule

bind ipv4_header_generator_top ipv4hg_checker u_ipv4hg_checker (.*);

// ----- sim/ipv4hg_header_checker.sv -----
// checker for the ipv4 header generator: predicts the header words and compares them
module ipv4hg_header_checker
    import ipv4hg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  t_req               i_in,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  t_word              i_out,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic [31:0]        i_prdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] source_reg;
    t_word       expected_words[$];
    int          fail_total = 0;

    assign o_fail_count = fail_total;

    // one's-complement sum with end-around carry over all ten words, checksum slot zero
    function automatic t_hdr_words build_header(t_req req, logic [31:0] src);
        t_hdr_words  hdr;
        logic [16:0] acc;
        logic [15:0] sum;
        logic [15:0] chk;
        hdr[0] = {IP_VERSION, IP_IHL, 8'h00};
        hdr[1] = req.payload_length + 16'(HDR_BYTES);
        hdr[2] = req.ident;
        hdr[3] = {IP_FLAGS_DF, 8'h00};
        hdr[4] = {IP_TTL, req.protocol};
        hdr[5] = 16'h0000;
        hdr[6] = src[31:16];
        hdr[7] = src[15:0];
        hdr[8] = req.dest_address[31:16];
        hdr[9] = req.dest_address[15:0];
        sum = 16'h0000;
        for (int k = 0; k < HDR_WORDS; k++) begin
            acc = {1'b0, sum} + {1'b0, hdr[k]};
            sum = acc[15:0] + 16'(acc[16]);
        end
        chk = ~sum;
        if (chk == 16'h0000) begin
            chk = WORD_ONES;
        end
        hdr[5] = chk;
        return hdr;
    endfunction

    always @(posedge i_clk) begin
        t_hdr_words hdr;
        t_word      exp_w;
        t_word      w;
        if (!i_rst_n) begin
            source_reg = 32'h0;
            expected_words.delete();
            o_words_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected header word %h index %0d", i_out.header_word,
                           i_out.word_index);
                    fail_total++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (i_out.header_word !== exp_w.header_word) begin
                        $error("header_word expected %h got %h", exp_w.header_word,
                               i_out.header_word);
                        fail_total++;
                    end
                    if (i_out.word_index !== exp_w.word_index) begin
                        $error("word_index expected %0d got %0d", exp_w.word_index,
                               i_out.word_index);
                        fail_total++;
                    end
                    if (i_out.last !== exp_w.last) begin
                        $error("last expected %b got %b", exp_w.last, i_out.last);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                hdr = build_header(i_in, source_reg);
                for (int k = 0; k < HDR_WORDS; k++) begin
                    w.header_word = hdr[k];
                    w.word_index  = IDX_W'(k);
                    w.last        = (k == HDR_WORDS - 1);
                    expected_words.push_back(w);
                end
            end
            if (i_psel && i_penable && i_pready
                    && (i_paddr >> 2) == PADDR_W'(REG_SOURCE_ADDRESS)) begin
                if (i_pwrite) begin
                    source_reg = i_pwdata;
                end else if (i_prdata !== source_reg) begin
                    $error("source_address expected %h got %h", source_reg, i_prdata);
                    fail_total++;
                end
            end
            o_words_pending <= expected_words.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
// testbench top for the ipv4 header generator: stimulus, register writes and verdict
module tb_top;
    import ipv4hg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // byte address with no register behind it
    localparam logic [PADDR_W-1:0] ADDR_UNUSED = PADDR_W'(4);
    localparam logic [PADDR_W-1:0] ADDR_SOURCE = PADDR_W'({REG_SOURCE_ADDRESS, 2'b00});

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_req               i_in;
    logic               o_out_valid;
    logic               i_out_ready;
    t_word              o_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int          fail_count;
    int          words_pending;
    int          in_mode;
    int          out_mode;
    logic [31:0] cur_source;

    ipv4_header_generator_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    ipv4hg_header_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_in            (i_in),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_out           (o_out),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_prdata        (prdata),
        .i_pready        (pready),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // 0: no idling, 1: a random gap on every call, 2: mostly back to back
    function automatic int pick_gap(int mode);
        if (mode == 1) begin
            return $urandom_range(0, 15);
        end else if (mode == 2) begin
            return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
        end
        return 0;
    endfunction

    function automatic t_req mk_req(logic [15:0] plen, logic [15:0] id, logic [31:0] dst,
                                    logic [7:0] prot);
        t_req r;
        r.payload_length = plen;
        r.ident          = id;
        r.dest_address   = dst;
        r.protocol       = prot;
        return r;
    endfunction

    // low destination half that makes the folded sum all ones, so the checksum inverts to zero
    function automatic logic [15:0] zero_sum_dest_low(t_req r, logic [31:0] src);
        logic [31:0] s;
        logic [15:0] tot;
        tot = r.payload_length + 16'(HDR_BYTES);
        s = 32'h4500 + 32'(tot) + 32'(r.ident) + 32'h4000 + 32'({8'd64, r.protocol})
            + 32'(src[31:16]) + 32'(src[15:0]) + 32'(r.dest_address[31:16]);
        s = (s & 32'hFFFF) + (s >> 16);
        s = (s & 32'hFFFF) + (s >> 16);
        return ~s[15:0];
    endfunction

    function automatic t_req rand_req();
        t_req r;
        int   kind;
        kind = $urandom_range(0, 15);
        r = mk_req(16'($urandom_range(0, 65515)), 16'($urandom), $urandom, 8'($urandom));
        if (kind == 0) begin
            r.payload_length = 16'($urandom_range(65515, 65535));
        end else if (kind == 1) begin
            r.payload_length = 16'($urandom_range(0, 64));
        end else if (kind == 2) begin
            r.dest_address[15:0] = zero_sum_dest_low(r, cur_source);
        end else if (kind == 3) begin
            r.protocol = ($urandom_range(0, 1) == 0) ? 8'd6 : 8'd17;
        end
        return r;
    endfunction

    // entered at a clock edge, returns at the edge where the request is taken
    task automatic send_req(t_req r, int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            i_in <= t_req'(72'({$urandom, $urandom, $urandom}));
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= r;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // drops psel after the access edge and idles before returning
    task automatic apb_access(logic wr, logic [PADDR_W-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (wr && (addr >> 2) == PADDR_W'(REG_SOURCE_ADDRESS)) begin
            cur_source = data;
        end
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (words_pending != 0);
        repeat (6) @(posedge i_clk);
    endtask

    // output side stalls, one draw per word
    initial begin
        int gap;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            gap = pick_gap(out_mode);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        t_req r;
        int   n_items;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cur_source = 32'h0;
        in_mode    = 0;
        out_mode   = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words at the reset source address
        send_req(mk_req(16'd0, 16'h0000, 32'h0000_0000, 8'h00), 0);
        send_req(mk_req(16'd65515, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF), 0);
        send_req(mk_req(16'd65516, 16'h0001, 32'h0000_0001, 8'd6), 0);
        send_req(mk_req(16'd65535, 16'hFFFE, 32'hFFFF_FFFE, 8'd17), 0);
        send_req(mk_req(16'h8000, 16'h5555, 32'hAAAA_AAAA, 8'h55), 0);
        send_req(mk_req(16'h7FFF, 16'hAAAA, 32'h5555_5555, 8'hAA), 0);
        send_req(mk_req(16'd1500, 16'h0001, 32'hC0A8_0001, 8'd17), 0);
        send_req(mk_req(16'd40, 16'h1234, 32'h0A00_0001, 8'd1), 0);
        r = mk_req(16'd100, 16'h1111, 32'hC0A8_0000, 8'd6);
        r.dest_address[15:0] = zero_sum_dest_low(r, cur_source);
        send_req(r, 0);
        r = mk_req(16'd0, 16'hFFFF, 32'hFFFF_0000, 8'hFF);
        r.dest_address[15:0] = zero_sum_dest_low(r, cur_source);
        send_req(r, 3);
        send_req(mk_req(16'd65534, 16'h8000, 32'h8000_0000, 8'h80), 0);
        drain();

        apb_access(1'b0, ADDR_SOURCE, 32'h0);
        for (int phase = 1; phase <= 5; phase++) begin
            case (phase)
                1: begin
                    apb_access(1'b1, ADDR_SOURCE, 32'hFFFF_FFFF);
                    in_mode  = 1;
                    out_mode = 1;
                    n_items  = 50;
                end
                2: begin
                    apb_access(1'b1, ADDR_SOURCE, $urandom);
                    // write to an address with no register must be ignored
                    apb_access(1'b1, ADDR_UNUSED, $urandom);
                    in_mode  = 0;
                    out_mode = 1;
                    n_items  = 50;
                end
                3: begin
                    apb_access(1'b1, ADDR_SOURCE, 32'h0);
                    in_mode  = 1;
                    out_mode = 0;
                    n_items  = 50;
                end
                4: begin
                    apb_access(1'b1, ADDR_SOURCE, $urandom);
                    in_mode  = 2;
                    out_mode = 2;
                    n_items  = 55;
                end
                default: begin
                    apb_access(1'b1, ADDR_SOURCE, $urandom);
                    in_mode  = 1;
                    out_mode = 2;
                    n_items  = 55;
                end
            endcase
            apb_access(1'b0, ADDR_SOURCE, 32'h0);
            for (int i = 0; i < n_items; i++) begin
                send_req(rand_req(), pick_gap(in_mode));
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ipv4hg_pkg.sv
rtl/ipv4hg_hdr_build.sv
rtl/ipv4_header_generator_top.sv
rtl/ipv4hg_checker.sv
sim/ipv4hg_header_checker.sv
sim/tb_top.sv
